@@ rtl/bounded_deque_with_value_removal_top_macros.svh @@
// assertion macros for the bounded deque block
// no dependencies; the checks compile away when SYNTH is defined
`ifndef BOUNDED_DEQUE_WITH_VALUE_REMOVAL_TOP_MACROS_SVH
`define BOUNDED_DEQUE_WITH_VALUE_REMOVAL_TOP_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define BDQ_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BDQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BDQ_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons, msg)
`define BDQ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons, msg)
`endif
`endif

@@ rtl/bdq_pkg.sv @@
// shared types and codes for the bounded deque block
// no dependencies
package bdq_pkg;

	localparam int DATA_W = 32;

	// command codes; code 7 is unused and acts as a no-op
	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_PEEK_FRONT = 3'd2,
		CMD_PEEK_BACK  = 3'd3,
		CMD_POP_FRONT  = 3'd4,
		CMD_POP_BACK   = 3'd5,
		CMD_REMOVE     = 3'd6
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_EXEC   = 5'b00010,
		S_RDWAIT = 5'b00100,
		S_SCAN   = 5'b01000,
		S_SHIFT  = 5'b10000
	} state_t;

endpackage

@@ rtl/bdq_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module bdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/bounded_deque_with_value_removal_top.sv @@
// bounded deque with remove-by-value, one command word per start, one result word per command
// push, no-op and an empty peek or pop raise the done strobe from S_EXEC, other peeks and pops from S_RDWAIT
// remove does one ram read per cycle: scan, then close the gap
// busy stays high until the strobe cycle; a new word is taken in that cycle already
// results cannot be stalled; reset clears count, front pointer and sequencer, not the ram
// uses bdq_pkg, bdq_ram and the assertion macro header
`include "bounded_deque_with_value_removal_top_macros.svh"
module bounded_deque_with_value_removal_top #(
	parameter int CAPACITY = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [2:0]                          command,
	input  logic signed [bdq_pkg::DATA_W-1:0]   value,
	output logic                                done,
	output logic signed [bdq_pkg::DATA_W-1:0]   out_value,
	output logic [1:0]                          status,
	output logic [$clog2(CAPACITY+1)-1:0]       count,
	output logic                                is_empty
);

	import bdq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
	localparam logic [CNT_W:0]   CAP_EXT  = (CNT_W + 1)'(CAPACITY);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t                      state_q;
	logic [2:0]                  cmd_q;
	logic [DATA_W-1:0]           val_q;
	logic [CNT_W-1:0]            count_q;
	logic [IDX_W-1:0]            front_q;
	logic [CNT_W-1:0]            pos_q;
	logic [IDX_W-1:0]            rd_addr_q;
	logic [IDX_W-1:0]            wr_slot_q;
	logic                        done_q;
	logic [DATA_W-1:0]           out_value_q;
	status_t                     status_q;

	logic [CNT_W-1:0]            pos_next;
	logic [CNT_W-1:0]            pos_inc;
	logic [CNT_W:0]              slot_sum;
	logic [IDX_W-1:0]            rd_addr;
	logic [IDX_W-1:0]            front_dec;
	logic [IDX_W-1:0]            front_inc;
	logic                        full;
	logic                        empty;
	logic                        more;
	logic                        match;
	logic                        we;
	logic [IDX_W-1:0]            waddr;
	logic [DATA_W-1:0]           wdata;
	logic [DATA_W-1:0]           rd_data;

	// status of the store
	assign full      = (count_q == CAP_CNT);
	assign empty     = (count_q == '0);
	assign pos_inc   = pos_q + 1'b1;
	assign more      = (pos_inc < count_q);
	assign match     = (rd_data == val_q);
	assign front_dec = (front_q == '0) ? LAST_IDX : front_q - 1'b1;
	assign front_inc = (front_q == LAST_IDX) ? '0 : front_q + 1'b1;

	// logical position to address this cycle
	always_comb begin
		pos_next = '0;
		unique case (state_q)
			S_EXEC: begin
				unique case (cmd_q)
					CMD_PEEK_BACK, CMD_POP_BACK: pos_next = count_q - 1'b1;
					CMD_PUSH_BACK:               pos_next = count_q;
					default:                     pos_next = '0;
				endcase
			end
			S_SCAN, S_SHIFT: pos_next = pos_inc;
			default:         pos_next = '0;
		endcase
	end

	// shared slot unit: front plus position, wrapped once
	assign slot_sum = (CNT_W + 1)'(front_q) + (CNT_W + 1)'(pos_next);
	always_comb begin
		logic [CNT_W:0] wrapped;
		wrapped = (slot_sum >= CAP_EXT) ? slot_sum - CAP_EXT : slot_sum;
		rd_addr = wrapped[IDX_W-1:0];
	end

	// single ram write port
	always_comb begin
		we    = 1'b0;
		waddr = rd_addr;
		wdata = val_q;
		if (state_q == S_SHIFT) begin
			we    = 1'b1;
			waddr = wr_slot_q;
			wdata = rd_data;
		end else if (state_q == S_EXEC && !full) begin
			if (cmd_q == CMD_PUSH_FRONT) begin
				we    = 1'b1;
				waddr = front_dec;
			end else if (cmd_q == CMD_PUSH_BACK) begin
				we    = 1'b1;
				waddr = rd_addr;
			end
		end
	end

	bdq_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			front_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q)
						CMD_PUSH_FRONT: begin
							if (!full) begin
								front_q <= front_dec;
								count_q <= count_q + 1'b1;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						CMD_PUSH_BACK: begin
							if (!full) begin
								count_q <= count_q + 1'b1;
							end
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
						CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_RDWAIT;
							end
						end
						CMD_REMOVE: begin
							if (empty) begin
								done_q  <= 1'b1;
								state_q <= S_IDLE;
							end else begin
								state_q <= S_SCAN;
							end
						end
						default: begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end
					endcase
				end
				S_RDWAIT: begin
					if (cmd_q == CMD_POP_FRONT) begin
						front_q <= front_inc;
						count_q <= count_q - 1'b1;
					end else if (cmd_q == CMD_POP_BACK) begin
						count_q <= count_q - 1'b1;
					end
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (match && more) begin
						state_q <= S_SHIFT;
					end else if (match) begin
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if (!more) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_SHIFT: begin
					if (!more) begin
						count_q <= count_q - 1'b1;
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command word, scan position and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q <= command;
					val_q <= value;
				end
			end
			S_EXEC: begin
				pos_q       <= '0;
				rd_addr_q   <= rd_addr;
				out_value_q <= '0;
				unique case (cmd_q)
					CMD_PUSH_FRONT, CMD_PUSH_BACK: status_q <= full ? ST_FULL : ST_OK;
					CMD_PEEK_FRONT, CMD_PEEK_BACK, CMD_POP_FRONT, CMD_POP_BACK:
						status_q <= empty ? ST_EMPTY : ST_OK;
					CMD_REMOVE: status_q <= ST_NOT_FOUND;
					default:    status_q <= ST_OK;
				endcase
			end
			S_RDWAIT: begin
				out_value_q <= rd_data;
				status_q    <= ST_OK;
			end
			S_SCAN: begin
				if (more) begin
					pos_q     <= pos_inc;
					rd_addr_q <= rd_addr;
				end
				if (match) begin
					wr_slot_q <= rd_addr_q;
					status_q  <= ST_OK;
				end
			end
			S_SHIFT: begin
				if (more) begin
					pos_q     <= pos_inc;
					rd_addr_q <= rd_addr;
					wr_slot_q <= rd_addr_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign out_value = out_value_q;
	assign status    = status_q;
	assign count     = count_q;
	assign is_empty  = empty;

	// checks
	`BDQ_ASSERT_IMPL(a_done_after_work, clk, arst_n, done_q, $past(state_q) != S_IDLE, "result word without a command in flight")
	`BDQ_ASSERT_NEXT(a_accept_goes_busy, clk, arst_n, start && !busy, busy, "accepted word did not start the sequencer")
	`BDQ_ASSERT_IMPL(a_count_moves_on_done, clk, arst_n, !$stable(count_q), done_q, "count changed outside a result cycle")
	`BDQ_ASSERT_IMPL(a_shift_in_range, clk, arst_n, state_q == S_SHIFT, pos_q < count_q, "gap closing ran past the last entry")

endmodule
